### hw/rtl/sorted_multiset_table_top_macros.svh
// Assertion helpers for the checker of the sorted multiset table.
`ifndef SORTED_MULTISET_TABLE_TOP_MACROS_SVH
`define SORTED_MULTISET_TABLE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SMT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sorted multiset table check failed");

// Next-cycle implication, disabled while reset is low.
`define SMT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sorted multiset table check failed");

`endif

### hw/rtl/smt_pkg.sv
package smt_pkg;

    localparam int SLOTS  = 16;
    localparam int USED_W = $clog2(SLOTS + 1);
    localparam int POS_W  = 4;
    localparam int CMP_W  = (USED_W > POS_W) ? USED_W : POS_W;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // Actions
    localparam logic [2:0] ACT_ADD        = 3'd0;
    localparam logic [2:0] ACT_REMOVE_ONE = 3'd1;
    localparam logic [2:0] ACT_REMOVE_ALL = 3'd2;
    localparam logic [2:0] ACT_LOOKUP     = 3'd3;
    localparam logic [2:0] ACT_READ_POS   = 3'd4;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_SAT       = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;

    // Commands broadcast to the cell chain
    localparam logic [1:0] OP_HOLD   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_SET    = 2'd2;
    localparam logic [1:0] OP_DROP   = 2'd3;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] value;
        logic [15:0]        amount;
        logic [3:0]         position;
    } t_req;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] found_value;
        logic [15:0]        count;
        logic [4:0]         entries_used;
    } t_rsp;

    typedef struct packed {
        logic               valid;
        logic signed [31:0] value;
        logic [15:0]        count;
    } t_cell;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] value;
        logic [15:0]        count;
    } t_cell_cmd;

endpackage

### hw/rtl/smt_cell.sv
module smt_cell import smt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic signed [31:0] i_key,
    input  t_cell_cmd          i_cmd,
    input  t_cell              i_left,
    input  logic               i_left_less,
    input  t_cell              i_right,
    output t_cell              o_cell,
    output logic               o_less,
    output logic               o_eq
);

    logic               r_valid, n_valid;
    logic signed [31:0] r_value, n_value;
    logic [15:0]        r_count, n_count;
    logic               r_less;
    logic               r_eq;

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        n_count = r_count;
        unique case (i_cmd.op)
            OP_INSERT: begin
                // open a gap at the first cell not below the key, shift the rest right
                if (!r_less) begin
                    if (i_left_less) begin
                        n_valid = 1'b1;
                        n_value = i_cmd.value;
                        n_count = i_cmd.count;
                    end else begin
                        n_valid = i_left.valid;
                        n_value = i_left.value;
                        n_count = i_left.count;
                    end
                end
            end
            OP_SET: begin
                if (r_eq) begin
                    n_count = i_cmd.count;
                end
            end
            OP_DROP: begin
                // close the gap: the hit cell and all after it pull from the right
                if (!r_less) begin
                    n_valid = i_right.valid;
                    n_value = i_right.value;
                    n_count = i_right.count;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_less  <= 1'b0;
            r_eq    <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_load) begin
                r_less <= r_valid && (r_value < i_key);
                r_eq   <= r_valid && (r_value == i_key);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_count <= n_count;
    end

    assign o_cell = '{valid: r_valid, value: r_value, count: r_count};
    assign o_less = r_less;
    assign o_eq   = r_eq;

endmodule

### hw/rtl/sorted_multiset_table_top.sv
// Sorted multiset table: holds up to SLOTS distinct signed 32-bit values in
// ascending order, each with a 16-bit count, in a row of cells. Each request
// runs in two steps: in the cycle it is accepted each cell compares its value
// against the request value and registers "below" and "equal" flags; in the
// finishing step, which waits while the response register is still full, the
// result is formed and every cell takes its new contents from itself or a
// neighbor (shift right to insert, shift left to drop). A new request is not
// taken before the previous one finishes: o_req_ready is low from acceptance
// until the finishing step. Responses sit in an output register, so a new
// request is taken while the previous response waits to be read. Lookup and
// read-position requests leave the table as is.
module sorted_multiset_table_top import smt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    logic              r_busy;
    t_req              r_req;
    logic [USED_W-1:0] r_used, n_used;
    logic              r_rsp_valid;
    t_rsp              r_rsp, n_rsp;

    logic      accept;
    logic      commit;
    t_cell_cmd cmd;
    logic [1:0] n_op;
    logic [15:0] n_count;

    t_cell cell_data [SLOTS];
    logic  cell_less [SLOTS];
    logic  cell_eq   [SLOTS];

    logic               hit;
    logic [15:0]        hit_count;
    logic signed [31:0] pos_value;
    logic [15:0]        pos_count;
    logic [16:0]        sum;
    logic [15:0]        dec;
    logic               full;
    logic               pos_ok;

    assign o_req_ready = !r_busy;
    assign accept      = i_req_valid && !r_busy;
    // finish the request once the response register is free
    assign commit      = r_busy && (!r_rsp_valid || i_rsp_ready);

    // Gather the hit entry and the entry at the requested position.
    always_comb begin
        hit       = 1'b0;
        hit_count = '0;
        pos_value = '0;
        pos_count = '0;
        for (int k = 0; k < SLOTS; k++) begin
            hit       = hit | cell_eq[k];
            hit_count = hit_count | (cell_eq[k] ? cell_data[k].count : 16'd0);
            if (k == int'(r_req.position)) begin
                pos_value = cell_data[k].value;
                pos_count = cell_data[k].count;
            end
        end
    end

    assign sum    = {1'b0, hit_count} + {1'b0, r_req.amount};
    assign dec    = (hit_count == 16'd0) ? 16'd0 : hit_count - 16'd1;
    assign full   = (r_used == USED_W'(SLOTS));
    assign pos_ok = (CMP_W'(r_req.position) < CMP_W'(r_used));

    // Decide the chain command and the response.
    always_comb begin
        n_op    = OP_HOLD;
        n_count = '0;
        n_used  = r_used;
        n_rsp.status      = ST_NOT_FOUND;
        n_rsp.found_value = r_req.value;
        n_rsp.count       = '0;
        unique case (r_req.action)
            ACT_ADD: begin
                if (hit) begin
                    n_op = OP_SET;
                    if (sum[16]) begin
                        n_count      = COUNT_MAX;
                        n_rsp.status = ST_SAT;
                    end else begin
                        n_count      = sum[15:0];
                        n_rsp.status = ST_OK;
                    end
                    n_rsp.count = n_count;
                end else if (r_req.amount == 16'd0) begin
                    n_rsp.status = ST_NOT_FOUND;
                end else if (full) begin
                    n_rsp.status = ST_FULL;
                end else begin
                    n_op         = OP_INSERT;
                    n_count      = r_req.amount;
                    n_used       = r_used + USED_W'(1);
                    n_rsp.status = ST_OK;
                    n_rsp.count  = r_req.amount;
                end
            end
            ACT_REMOVE_ONE: begin
                if (hit) begin
                    n_rsp.status = ST_OK;
                    n_rsp.count  = dec;
                    n_count      = dec;
                    if (dec == 16'd0) begin
                        n_op   = OP_DROP;
                        n_used = r_used - USED_W'(1);
                    end else begin
                        n_op = OP_SET;
                    end
                end
            end
            ACT_REMOVE_ALL: begin
                if (hit) begin
                    n_op         = OP_DROP;
                    n_used       = r_used - USED_W'(1);
                    n_rsp.status = ST_OK;
                end
            end
            ACT_LOOKUP: begin
                if (hit) begin
                    n_rsp.status = ST_OK;
                    n_rsp.count  = hit_count;
                end
            end
            ACT_READ_POS: begin
                if (pos_ok) begin
                    n_rsp.status      = ST_OK;
                    n_rsp.found_value = pos_value;
                    n_rsp.count       = pos_count;
                end else begin
                    n_rsp.status      = ST_EMPTY;
                    n_rsp.found_value = '0;
                end
            end
            default: begin
            end
        endcase
        n_rsp.entries_used = 5'(n_used);
    end

    // Broadcast the command only in the finishing cycle; hold otherwise.
    assign cmd = '{op: commit ? n_op : OP_HOLD, value: r_req.value, count: n_count};

    for (genvar k = 0; k < SLOTS; k++) begin : g_cell
        t_cell left_data;
        logic  left_less;
        t_cell right_data;

        if (k == 0) begin : g_first
            assign left_data = '0;
            assign left_less = 1'b1;
        end else begin : g_mid
            assign left_data = cell_data[k-1];
            assign left_less = cell_less[k-1];
        end

        if (k == SLOTS - 1) begin : g_last
            assign right_data = '0;
        end else begin : g_inner
            assign right_data = cell_data[k+1];
        end

        smt_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_load      (accept),
            .i_key       (i_req.value),
            .i_cmd       (cmd),
            .i_left      (left_data),
            .i_left_less (left_less),
            .i_right     (right_data),
            .o_cell      (cell_data[k]),
            .o_less      (cell_less[k]),
            .o_eq        (cell_eq[k])
        );
    end

    // Control: busy flag, entry count, response valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_used      <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (commit) begin
                r_busy <= 1'b0;
            end
            if (commit) begin
                r_used      <= n_used;
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // Payload: hold the request until it finishes, load the response.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
        if (commit) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

### hw/rtl/smt_checker.sv
`include "sorted_multiset_table_top_macros.svh"

module smt_checker import smt_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic o_req_ready,
    input logic o_rsp_valid,
    input logic i_rsp_ready,
    input t_rsp o_rsp
);

    logic req_take;
    logic rsp_stall;
    logic rsp_empty;
    logic rsp_miss;
    logic empty_zero;
    logic used_ok;

    assign req_take   = i_req_valid && o_req_ready;
    assign rsp_stall  = o_rsp_valid && !i_rsp_ready;
    assign rsp_empty  = o_rsp_valid && (o_rsp.status == ST_EMPTY);
    assign rsp_miss   = o_rsp_valid &&
                        ((o_rsp.status == ST_NOT_FOUND) || (o_rsp.status == ST_FULL));
    assign empty_zero = (o_rsp.count == 16'd0) && (o_rsp.found_value == 32'sd0);
    assign used_ok    = 32'(o_rsp.entries_used) <= 32'(SLOTS);

    // one request in flight: ready drops right after a request is taken
    `SMT_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, req_take, !o_req_ready)

    // a stalled response holds
    `SMT_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, rsp_stall, o_rsp_valid && $stable(o_rsp))

    // an empty position reads as zero
    `SMT_ASSERT_NOW(a_empty_zero, i_clk, i_rst_n, rsp_empty, empty_zero)

    // a miss or a full table reports no count
    `SMT_ASSERT_NOW(a_miss_zero, i_clk, i_rst_n, rsp_miss, o_rsp.count == 16'd0)

    // the entry count never exceeds the table size
    `SMT_ASSERT_NOW(a_used_bound, i_clk, i_rst_n, o_rsp_valid && (SLOTS < 32), used_ok)

endmodule

bind sorted_multiset_table_top smt_checker u_smt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_ready (o_req_ready),
    .o_rsp_valid (o_rsp_valid),
    .i_rsp_ready (i_rsp_ready),
    .o_rsp       (o_rsp)
);
